### src/ps2mct_pkg.sv
package ps2mct_pkg;

    localparam int COORD_BITS     = 10;
    localparam int SUM_BITS       = COORD_BITS + 2;
    localparam int CFG_INDEX_BITS = 3;
    localparam int BUTTON_BITS    = 3;
    localparam int QUEUE_DEPTH    = 2;
    localparam int QPTR_BITS      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCOUNT_BITS    = $clog2(QUEUE_DEPTH + 1);

    typedef logic [COORD_BITS-1:0] coord_t;
    typedef logic signed [SUM_BITS-1:0] coord_sum_t;

    localparam coord_t RESET_LIMIT_X       = coord_t'(319);
    localparam coord_t RESET_LIMIT_Y       = coord_t'(239);
    localparam coord_t RESET_REGION_LEFT   = coord_t'(301);
    localparam coord_t RESET_REGION_TOP    = coord_t'(4);
    localparam coord_t RESET_REGION_WIDTH  = coord_t'(15);
    localparam coord_t RESET_REGION_HEIGHT = coord_t'(12);

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_LIMIT_X       = 3'd0,
        CFG_LIMIT_Y       = 3'd1,
        CFG_REGION_LEFT   = 3'd2,
        CFG_REGION_TOP    = 3'd3,
        CFG_REGION_WIDTH  = 3'd4,
        CFG_REGION_HEIGHT = 3'd5
    } cfg_index_t;

    typedef enum logic [1:0] {
        SLOT_STATUS = 2'd0,
        SLOT_MOVE_X = 2'd1,
        SLOT_MOVE_Y = 2'd2
    } slot_t;

    typedef struct packed {
        logic [BUTTON_BITS-1:0] buttons;
        logic [7:0]             move_x;
        logic [7:0]             move_y;
    } packet_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    // x >= limit gives limit - 1, then anything negative gives zero
    function automatic coord_t clamp_coord(coord_sum_t v, coord_t limit);
        coord_sum_t lim_s;
        coord_sum_t r;
        lim_s = coord_sum_t'(limit);
        r     = v;
        if (v >= lim_s) begin
            r = lim_s - coord_sum_t'(1);
        end
        if (r[SUM_BITS-1]) begin
            r = '0;
        end
        return r[COORD_BITS-1:0];
    endfunction

endpackage

### src/ps2mct_front.sv
module ps2mct_front (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [7:0]                s_rx_byte,
    output logic                      q_push,
    output ps2mct_pkg::packet_t       q_wdata,
    input  ps2mct_pkg::queue_status_t q_status
);

    ps2mct_pkg::slot_t slot_reg, slot_next;
    logic [7:0]        status_reg, status_next;
    logic [7:0]        move_x_reg, move_x_next;
    logic              accept;

    // only the last byte of a packet needs room in the queue
    assign s_ready = (slot_reg != ps2mct_pkg::SLOT_MOVE_Y) || !q_status.full;
    assign accept  = s_valid && s_ready;

    assign q_wdata.buttons = status_reg[ps2mct_pkg::BUTTON_BITS-1:0];
    assign q_wdata.move_x  = move_x_reg;
    assign q_wdata.move_y  = s_rx_byte;

    always_comb begin
        slot_next   = slot_reg;
        status_next = status_reg;
        move_x_next = move_x_reg;
        q_push      = 1'b0;
        if (accept) begin
            case (slot_reg)
                ps2mct_pkg::SLOT_MOVE_X: begin
                    move_x_next = s_rx_byte;
                    slot_next   = ps2mct_pkg::SLOT_MOVE_Y;
                end
                ps2mct_pkg::SLOT_MOVE_Y: begin
                    q_push    = 1'b1;
                    slot_next = ps2mct_pkg::SLOT_STATUS;
                end
                default: begin
                    status_next = s_rx_byte;
                    slot_next   = ps2mct_pkg::SLOT_MOVE_X;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg   <= ps2mct_pkg::SLOT_STATUS;
            status_reg <= '0;
            move_x_reg <= '0;
        end else begin
            slot_reg   <= slot_next;
            status_reg <= status_next;
            move_x_reg <= move_x_next;
        end
    end

endmodule

### src/ps2mct_queue.sv
module ps2mct_queue (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      push,
    input  ps2mct_pkg::packet_t       wdata,
    input  logic                      pop,
    output ps2mct_pkg::packet_t       rdata,
    output ps2mct_pkg::queue_status_t status
);

    localparam logic [ps2mct_pkg::QPTR_BITS-1:0] LAST_PTR =
        ps2mct_pkg::QPTR_BITS'(ps2mct_pkg::QUEUE_DEPTH - 1);
    localparam logic [ps2mct_pkg::QCOUNT_BITS-1:0] FULL_COUNT =
        ps2mct_pkg::QCOUNT_BITS'(ps2mct_pkg::QUEUE_DEPTH);

    ps2mct_pkg::packet_t                  mem_reg [ps2mct_pkg::QUEUE_DEPTH];
    logic [ps2mct_pkg::QPTR_BITS-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [ps2mct_pkg::QPTR_BITS-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [ps2mct_pkg::QCOUNT_BITS-1:0]   count_reg, count_next;
    logic                                 do_push, do_pop;

    assign status.full  = (count_reg == FULL_COUNT);
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign rdata        = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

### src/ps2mct_back.sv
module ps2mct_back (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  ps2mct_pkg::packet_t                      q_rdata,
    input  ps2mct_pkg::queue_status_t                q_status,
    output logic                                     q_pop,
    input  logic                                     cfg_wr_en,
    input  logic [ps2mct_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  ps2mct_pkg::coord_t                       cfg_wdata,
    output logic                                     m_valid,
    input  logic                                     m_ready,
    output ps2mct_pkg::coord_t                       m_pos_x,
    output ps2mct_pkg::coord_t                       m_pos_y,
    output logic                                     m_left_down,
    output logic                                     m_right_down,
    output logic                                     m_middle_down,
    output logic                                     m_region_click
);

    localparam int EDGE_BITS = ps2mct_pkg::COORD_BITS + 1;

    ps2mct_pkg::coord_t limit_x_reg, limit_y_reg;
    ps2mct_pkg::coord_t region_left_reg, region_top_reg;
    ps2mct_pkg::coord_t region_width_reg, region_height_reg;

    ps2mct_pkg::coord_t cursor_x_reg, cursor_y_reg;
    logic               prev_left_reg;

    logic                                s1_valid_reg;
    ps2mct_pkg::coord_t                  s1_x_reg, s1_y_reg;
    logic [ps2mct_pkg::BUTTON_BITS-1:0]  s1_buttons_reg;
    logic                                s1_new_left_reg;

    logic               out_valid_reg;
    ps2mct_pkg::coord_t out_x_reg, out_y_reg;
    logic [ps2mct_pkg::BUTTON_BITS-1:0] out_buttons_reg;
    logic               out_click_reg;

    logic                    out_advance, take;
    ps2mct_pkg::coord_sum_t  dx, dy, nx, ny;
    ps2mct_pkg::coord_t      x_next, y_next;
    logic [EDGE_BITS-1:0]    right_edge, bottom_edge;
    logic                    in_rect;

    assign out_advance = s1_valid_reg && (!out_valid_reg || m_ready);
    assign take        = !q_status.empty && (!s1_valid_reg || out_advance);
    assign q_pop       = take;

    // stage 1: move and clamp the cursor
    assign dx     = ps2mct_pkg::SUM_BITS'(signed'(q_rdata.move_x));
    assign dy     = ps2mct_pkg::SUM_BITS'(signed'(q_rdata.move_y));
    assign nx     = ps2mct_pkg::coord_sum_t'(cursor_x_reg) + dx;
    assign ny     = ps2mct_pkg::coord_sum_t'(cursor_y_reg) - dy;
    assign x_next = ps2mct_pkg::clamp_coord(nx, limit_x_reg);
    assign y_next = ps2mct_pkg::clamp_coord(ny, limit_y_reg);

    // stage 2: rectangle test, edges summed one bit wider so they never wrap
    assign right_edge  = EDGE_BITS'(region_left_reg) + EDGE_BITS'(region_width_reg);
    assign bottom_edge = EDGE_BITS'(region_top_reg) + EDGE_BITS'(region_height_reg);
    assign in_rect = (s1_x_reg >= region_left_reg) && (EDGE_BITS'(s1_x_reg) < right_edge) &&
                     (s1_y_reg >= region_top_reg) && (EDGE_BITS'(s1_y_reg) < bottom_edge);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_x_reg       <= ps2mct_pkg::RESET_LIMIT_X;
            limit_y_reg       <= ps2mct_pkg::RESET_LIMIT_Y;
            region_left_reg   <= ps2mct_pkg::RESET_REGION_LEFT;
            region_top_reg    <= ps2mct_pkg::RESET_REGION_TOP;
            region_width_reg  <= ps2mct_pkg::RESET_REGION_WIDTH;
            region_height_reg <= ps2mct_pkg::RESET_REGION_HEIGHT;
        end else if (cfg_wr_en) begin
            case (ps2mct_pkg::cfg_index_t'(cfg_index))
                ps2mct_pkg::CFG_LIMIT_X:       limit_x_reg       <= cfg_wdata;
                ps2mct_pkg::CFG_LIMIT_Y:       limit_y_reg       <= cfg_wdata;
                ps2mct_pkg::CFG_REGION_LEFT:   region_left_reg   <= cfg_wdata;
                ps2mct_pkg::CFG_REGION_TOP:    region_top_reg    <= cfg_wdata;
                ps2mct_pkg::CFG_REGION_WIDTH:  region_width_reg  <= cfg_wdata;
                ps2mct_pkg::CFG_REGION_HEIGHT: region_height_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cursor_x_reg  <= ps2mct_pkg::RESET_LIMIT_X >> 1;
            cursor_y_reg  <= ps2mct_pkg::RESET_LIMIT_Y >> 1;
            prev_left_reg <= 1'b0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (take) begin
                cursor_x_reg  <= x_next;
                cursor_y_reg  <= y_next;
                prev_left_reg <= q_rdata.buttons[0];
                s1_valid_reg  <= 1'b1;
            end else if (out_advance) begin
                s1_valid_reg  <= 1'b0;
            end
            if (out_advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            s1_x_reg        <= x_next;
            s1_y_reg        <= y_next;
            s1_buttons_reg  <= q_rdata.buttons;
            s1_new_left_reg <= q_rdata.buttons[0] && !prev_left_reg;
        end
        if (out_advance) begin
            out_x_reg       <= s1_x_reg;
            out_y_reg       <= s1_y_reg;
            out_buttons_reg <= s1_buttons_reg;
            out_click_reg   <= s1_new_left_reg && in_rect;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_pos_x        = out_x_reg;
    assign m_pos_y        = out_y_reg;
    assign m_left_down    = out_buttons_reg[0];
    assign m_right_down   = out_buttons_reg[1];
    assign m_middle_down  = out_buttons_reg[2];
    assign m_region_click = out_click_reg;

endmodule

### src/ps2_mouse_cursor_tracker_top.sv
// PS/2 mouse cursor tracker. Takes one received mouse byte per cycle on the s_ side
// while s_ready is high and groups every three words into a packet (status, x move,
// y move). Each complete packet moves the cursor (x plus the x move, y minus the y
// move), clamps each coordinate to 0 .. limit - 1 and delivers one result word on the
// m_ side with the position, the three button bits and a click flag for a new left
// press inside the configured rectangle; the first two bytes of a packet give no
// result. Sustained rate is one byte per cycle while the queue has room, so at most
// one result per three bytes. A packet enters the queue when its last byte is
// accepted, then moves into the cursor stage registers and from there, with the
// rectangle test, into the output register; a two-entry queue lets byte intake
// continue while results stall. Configuration writes take effect at once and are
// meant to happen only while the block is idle; a write to an index past the last
// register is ignored.
module ps2_mouse_cursor_tracker_top (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [7:0]                            s_rx_byte,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [ps2mct_pkg::COORD_BITS-1:0]     m_pos_x,
    output logic [ps2mct_pkg::COORD_BITS-1:0]     m_pos_y,
    output logic                                  m_left_down,
    output logic                                  m_right_down,
    output logic                                  m_middle_down,
    output logic                                  m_region_click,
    input  logic                                  cfg_wr_en,
    input  logic [ps2mct_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [ps2mct_pkg::COORD_BITS-1:0]     cfg_wdata
);

    logic                      q_push, q_pop;
    ps2mct_pkg::packet_t       q_wdata, q_rdata;
    ps2mct_pkg::queue_status_t q_status;

    ps2mct_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_rx_byte (s_rx_byte),
        .q_push    (q_push),
        .q_wdata   (q_wdata),
        .q_status  (q_status)
    );

    ps2mct_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wdata   (q_wdata),
        .pop     (q_pop),
        .rdata   (q_rdata),
        .status  (q_status)
    );

    ps2mct_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_rdata        (q_rdata),
        .q_status       (q_status),
        .q_pop          (q_pop),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_pos_x        (m_pos_x),
        .m_pos_y        (m_pos_y),
        .m_left_down    (m_left_down),
        .m_right_down   (m_right_down),
        .m_middle_down  (m_middle_down),
        .m_region_click (m_region_click)
    );

endmodule

### src/ps2mct_checker.sv
module ps2mct_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              m_valid,
    input logic                              m_ready,
    input logic [ps2mct_pkg::COORD_BITS-1:0] m_pos_x,
    input logic [ps2mct_pkg::COORD_BITS-1:0] m_pos_y,
    input logic                              m_left_down,
    input logic                              m_region_click
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_pos_x) && $stable(m_pos_y)
            && $stable(m_region_click))
        else $error("result changed while stalled");

    a_click_needs_left: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (!m_region_click || m_left_down))
        else $error("click reported without left button");

    // clamp never yields the all-ones code
    a_clamped: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_pos_x != '1) && (m_pos_y != '1))
        else $error("position outside clamp range");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

bind ps2_mouse_cursor_tracker_top ps2mct_checker u_checker (.*);
